### rtl/csv_record_tokenizer_core_defines.svh
`ifndef CSV_RECORD_TOKENIZER_CORE_DEFINES_SVH
`define CSV_RECORD_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define CRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("crt: same-cycle check failed");

// Next-cycle implication, idle during reset.
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("crt: next-cycle check failed");

`endif

### rtl/crt_pkg.sv
package crt_pkg;

    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] DEF_DELIMITER = 8'd44;
    localparam logic [7:0] DEF_QUOTE     = 8'd34;
    localparam logic [6:0] DEF_COL_LIMIT = 7'd64;

    // result queue: depth and most results one byte can cause
    localparam int Q_DEPTH  = 4;
    localparam int EMIT_MAX = 2;

    typedef enum logic [2:0] {
        CFG_DELIMITER   = 3'd0,
        CFG_QUOTE       = 3'd1,
        CFG_ESCAPE      = 3'd2,
        CFG_NULL_TEXT   = 3'd3,
        CFG_NULL_LENGTH = 3'd4,
        CFG_COL_LIMIT   = 3'd5,
        CFG_MIN_COLUMNS = 3'd6,
        CFG_NOT_NULL    = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        EV_DATA       = 2'd0,
        EV_FIELD_END  = 2'd1,
        EV_RECORD_END = 2'd2
    } t_event_kind;

    typedef enum logic [1:0] {
        RS_OK           = 2'd0,
        RS_TOO_MANY     = 2'd1,
        RS_TOO_FEW      = 2'd2,
        RS_UNTERMINATED = 2'd3
    } t_rec_status;

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic [7:0] quote_char;
        logic [7:0] escape_char;
        logic [3:0] null_length;
        logic [6:0] column_limit;
        logic [6:0] min_columns;
    } t_cfg;

    typedef struct packed {
        logic       inside_quotes;
        logic       pending_escape;
        logic       pending_cr;
        logic [5:0] current_column;
        logic [6:0] fields_seen;
        logic [3:0] raw_field_length;
        logic       null_still_matches;
        logic       quote_seen_in_field;
        logic       line_has_bytes;
    } t_state;

    typedef struct packed {
        t_event_kind kind;
        logic [7:0]  data_byte;
        logic [5:0]  column_index;
        logic        field_is_null;
        logic [6:0]  column_count;
        t_rec_status status;
        logic        last_of_run;
    } t_result;

    function automatic t_state crt_start_field(t_state s);
        t_state r;
        r = s;
        r.raw_field_length    = 4'd0;
        r.null_still_matches  = 1'b1;
        r.quote_seen_in_field = 1'b0;
        return r;
    endfunction

    function automatic t_state crt_start_record();
        t_state r;
        r = '0;
        r.fields_seen        = 7'd1;
        r.null_still_matches = 1'b1;
        return r;
    endfunction

endpackage

### rtl/crt_in_if.sv
interface crt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

### rtl/crt_out_if.sv
interface crt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] data_byte;
    logic [5:0] column_index;
    logic       field_is_null;
    logic [6:0] column_count;
    logic [1:0] record_status;
    logic       last_of_run;

    modport source (
        output valid, output event_kind, output data_byte, output column_index,
        output field_is_null, output column_count, output record_status,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input event_kind, input data_byte, input column_index,
        input field_is_null, input column_count, input record_status,
        input last_of_run, output ready
    );
endinterface

### rtl/csv_record_tokenizer_core.sv
// Channel     | Dir | Modport | Request carries
// ------------+-----+---------+----------------------------------------------
// i_in_chan   | in  | sink    | one raw byte or an end-of-input marker
// o_out_chan  | out | source  | one event: data byte, field end, record end
// i_cfg_*     | in  | -       | register write: enable, index, 64-bit data
//
// One input request is taken per cycle while input ready is high; its state
// update is a single pass of logic from the registered tokenizer state to the
// next state. A byte causes zero, one or two events, written into a 4-entry
// result queue; the output drains one event per cycle while its ready is high.
// Input ready is high while the queue has room for two events (count <= 2).
// Reset (i_rst_n low, synchronous) sets registers to defaults and empties queue.
`include "csv_record_tokenizer_core_defines.svh"

module csv_record_tokenizer_core #(
    parameter int MAX_COLUMNS    = 64,
    parameter int NULL_MAX_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crt_in_if.sink      i_in_chan,
    crt_out_if.source   o_out_chan,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import crt_pkg::*;

    localparam int NB_IW = (NULL_MAX_BYTES > 1) ? $clog2(NULL_MAX_BYTES) : 1;
    localparam int COL_IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int QIW = $clog2(Q_DEPTH);
    localparam int QCW = QIW + 1;
    localparam logic [6:0] MAX_COL7 = 7'(MAX_COLUMNS);
    localparam logic [6:0] FS_SAT   = 7'(MAX_COLUMNS + 1);
    localparam logic [3:0] NB4      = 4'(NULL_MAX_BYTES);

    typedef logic [NULL_MAX_BYTES-1:0][7:0] t_null_text;
    typedef logic [MAX_COLUMNS-1:0]         t_mask;

    // state after one sub-step plus at most one event
    typedef struct packed {
        t_state  st;
        logic    emit;
        t_result ev;
    } t_step;

    // ---------------- configuration ----------------
    t_cfg       r_cfg;
    t_null_text r_null_text;
    t_mask      r_not_null_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_char <= DEF_DELIMITER;
            r_cfg.quote_char     <= DEF_QUOTE;
            r_cfg.escape_char    <= DEF_QUOTE;
            r_cfg.null_length    <= 4'd0;
            r_cfg.column_limit   <= DEF_COL_LIMIT;
            r_cfg.min_columns    <= 7'd0;
            r_null_text          <= '0;
            r_not_null_mask      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DELIMITER:   r_cfg.delimiter_char <= i_cfg_data[7:0];
                CFG_QUOTE:       r_cfg.quote_char     <= i_cfg_data[7:0];
                CFG_ESCAPE:      r_cfg.escape_char    <= i_cfg_data[7:0];
                CFG_NULL_TEXT:   r_null_text     <= i_cfg_data[8*NULL_MAX_BYTES-1:0];
                CFG_NULL_LENGTH: r_cfg.null_length    <= i_cfg_data[3:0];
                CFG_COL_LIMIT:   r_cfg.column_limit   <= i_cfg_data[6:0];
                CFG_MIN_COLUMNS: r_cfg.min_columns    <= i_cfg_data[6:0];
                CFG_NOT_NULL:    r_not_null_mask <= i_cfg_data[MAX_COLUMNS-1:0];
            endcase
        end
    end

    // ---------------- tokenizer step helpers ----------------
    // Last usable column: min(limit, MAX_COLUMNS) - 1, or 0 for a zero limit.
    function automatic logic [5:0] f_last_col(t_cfg c);
        logic [6:0] lim;
        lim = (c.column_limit < MAX_COL7) ? c.column_limit : MAX_COL7;
        return (lim == 7'd0) ? 6'd0 : 6'(lim - 7'd1);
    endfunction

    function automatic logic f_field_null(t_state s, t_cfg c, t_mask m);
        logic v;
        v = 1'b1;
        if (c.column_limit == 7'd0 || s.quote_seen_in_field || !s.null_still_matches)
            v = 1'b0;
        if (c.null_length > NB4 || s.raw_field_length != c.null_length)
            v = 1'b0;
        if (m[s.current_column[COL_IW-1:0]])
            v = 1'b0;
        return v;
    endfunction

    function automatic t_result f_ev(t_event_kind k, logic [7:0] b, t_state s,
                                     logic nul, logic [6:0] cnt, t_rec_status rs);
        t_result e;
        e.kind          = k;
        e.data_byte     = b;
        e.column_index  = s.current_column;
        e.field_is_null = nul;
        e.column_count  = cnt;
        e.status        = rs;
        e.last_of_run   = 1'b0;
        return e;
    endfunction

    function automatic t_step f_end_record(t_state s, logic unterm, t_cfg c, t_mask m);
        t_step       r;
        logic [6:0]  cnt;
        t_rec_status rs;
        cnt = (c.column_limit == 7'd0 && !s.line_has_bytes) ? 7'd0 : s.fields_seen;
        priority if (unterm)                rs = RS_UNTERMINATED;
        else if (cnt > c.column_limit)      rs = RS_TOO_MANY;
        else if (cnt < c.min_columns)       rs = RS_TOO_FEW;
        else                                rs = RS_OK;
        r.ev   = f_ev(EV_RECORD_END, 8'd0, s, f_field_null(s, c, m), cnt, rs);
        r.emit = 1'b1;
        r.st   = crt_start_record();
        return r;
    endfunction

    function automatic t_step f_byte_outside(t_state s, logic [7:0] b, t_cfg c,
                                             t_mask m, t_null_text nt);
        t_step r;
        r      = '0;
        r.st   = s;
        priority if (b == c.quote_char) begin
            r.st.inside_quotes       = 1'b1;
            r.st.quote_seen_in_field = 1'b1;
            r.st.line_has_bytes      = 1'b1;
        end else if (b == CH_CR) begin
            r.st.pending_cr = 1'b1;
        end else if (b == CH_LF) begin
            r = f_end_record(s, 1'b0, c, m);
        end else if (b == c.delimiter_char) begin
            r.emit = 1'b1;
            r.ev   = f_ev(EV_FIELD_END, 8'd0, s, f_field_null(s, c, m), 7'd0, RS_OK);
            r.st.line_has_bytes = 1'b1;
            if (s.current_column < f_last_col(c))
                r.st.current_column = s.current_column + 6'd1;
            if (s.fields_seen < FS_SAT)
                r.st.fields_seen = s.fields_seen + 7'd1;
            r.st = crt_start_field(r.st);
        end else begin
            r.emit = 1'b1;
            r.ev   = f_ev(EV_DATA, b, s, 1'b0, 7'd0, RS_OK);
            r.st.line_has_bytes = 1'b1;
            // running compare against the null string
            if (s.raw_field_length >= NB4)
                r.st.null_still_matches = 1'b0;
            else if (nt[s.raw_field_length[NB_IW-1:0]] != b)
                r.st.null_still_matches = 1'b0;
            if (s.raw_field_length != 4'hF)
                r.st.raw_field_length = s.raw_field_length + 4'd1;
        end
        return r;
    endfunction

    function automatic t_step f_byte_inside(t_state s, logic [7:0] b, t_cfg c);
        t_step r;
        r    = '0;
        r.st = s;
        r.st.line_has_bytes = 1'b1;
        priority if (b == c.escape_char) begin
            r.st.pending_escape = 1'b1;
        end else if (b == c.quote_char) begin
            r.st.inside_quotes = 1'b0;
        end else begin
            r.emit = 1'b1;
            r.ev   = f_ev(EV_DATA, b, s, 1'b0, 7'd0, RS_OK);
        end
        return r;
    endfunction

    // ---------------- single-pass step ----------------
    t_state      r_st;
    t_state      n_st;
    t_result     n_ev0;
    t_result     n_ev1;
    logic        n_v0;
    logic        n_v1;
    logic        in_acc;

    assign in_acc = i_in_chan.valid && i_in_chan.ready;

    always_comb begin
        t_state     s1;
        t_step      a;
        t_step      b;
        logic [7:0] ch;
        ch   = i_in_chan.in_byte;
        s1   = r_st;
        a    = '0;
        b    = '0;
        a.st = r_st;
        b.st = r_st;
        if (i_in_chan.end_of_input) begin
            // flush a pending escape, then close the record if it holds anything
            if (s1.pending_escape) begin
                s1.pending_escape = 1'b0;
                if (r_cfg.escape_char == r_cfg.quote_char) begin
                    s1.inside_quotes = 1'b0;
                end else begin
                    a.emit = 1'b1;
                    a.ev   = f_ev(EV_DATA, r_cfg.escape_char, s1, 1'b0, 7'd0, RS_OK);
                end
            end
            priority if (s1.pending_cr)
                b = f_end_record(s1, 1'b0, r_cfg, r_not_null_mask);
            else if (s1.inside_quotes)
                b = f_end_record(s1, 1'b1, r_cfg, r_not_null_mask);
            else if (s1.line_has_bytes)
                b = f_end_record(s1, 1'b0, r_cfg, r_not_null_mask);
            else begin
                b.emit = 1'b0;
                b.st   = crt_start_record();
            end
        end else if (r_st.pending_escape) begin
            s1.pending_escape = 1'b0;
            priority if (ch == r_cfg.quote_char || ch == r_cfg.escape_char) begin
                a.emit = 1'b1;
                a.ev   = f_ev(EV_DATA, ch, s1, 1'b0, 7'd0, RS_OK);
                b.st   = s1;
            end else if (r_cfg.escape_char == r_cfg.quote_char) begin
                // the escape was a closing quote
                s1.inside_quotes = 1'b0;
                b = f_byte_outside(s1, ch, r_cfg, r_not_null_mask, r_null_text);
            end else begin
                a.emit = 1'b1;
                a.ev   = f_ev(EV_DATA, r_cfg.escape_char, s1, 1'b0, 7'd0, RS_OK);
                b = f_byte_inside(s1, ch, r_cfg);
            end
        end else if (r_st.pending_cr) begin
            s1.pending_cr = 1'b0;
            a = f_end_record(s1, 1'b0, r_cfg, r_not_null_mask);
            if (ch != CH_LF)
                b = f_byte_outside(a.st, ch, r_cfg, r_not_null_mask, r_null_text);
            else
                b.st = a.st;
        end else if (r_st.inside_quotes) begin
            b = f_byte_inside(r_st, ch, r_cfg);
        end else begin
            b = f_byte_outside(r_st, ch, r_cfg, r_not_null_mask, r_null_text);
        end

        n_st  = b.st;
        // pack the events into the low slots, mark the last one
        n_v0  = a.emit || b.emit;
        n_v1  = a.emit && b.emit;
        n_ev0 = a.emit ? a.ev : b.ev;
        n_ev1 = b.ev;
        if (n_v1)
            n_ev1.last_of_run = 1'b1;
        else
            n_ev0.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_st <= crt_start_record();
        else if (in_acc)
            r_st <= n_st;
    end

    // ---------------- result queue ----------------
    t_result        r_q [Q_DEPTH];
    logic [QIW-1:0] r_wptr;
    logic [QIW-1:0] r_rptr;
    logic [QCW-1:0] r_count;
    logic [QCW-1:0] n_count;
    logic [1:0]     n_push;
    logic           out_pop;

    assign out_pop = o_out_chan.valid && o_out_chan.ready;
    assign n_push  = in_acc ? (2'(n_v0) + 2'(n_v1)) : 2'd0;
    assign n_count = r_count + QCW'(n_push) - QCW'(out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + QIW'(n_push);
            r_rptr  <= r_rptr + QIW'(out_pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_v0)
            r_q[r_wptr] <= n_ev0;
        if (in_acc && n_v1)
            r_q[QIW'(r_wptr + 1'b1)] <= n_ev1;
    end

    assign i_in_chan.ready = (r_count <= QCW'(Q_DEPTH - EMIT_MAX));

    assign o_out_chan.valid         = (r_count != '0);
    assign o_out_chan.event_kind    = r_q[r_rptr].kind;
    assign o_out_chan.data_byte     = r_q[r_rptr].data_byte;
    assign o_out_chan.column_index  = r_q[r_rptr].column_index;
    assign o_out_chan.field_is_null = r_q[r_rptr].field_is_null;
    assign o_out_chan.column_count  = r_q[r_rptr].column_count;
    assign o_out_chan.record_status = r_q[r_rptr].status;
    assign o_out_chan.last_of_run   = r_q[r_rptr].last_of_run;

    // ---------------- assertions ----------------
    `CRT_ASSERT_NOW(a_cr_escape_excl, i_clk, i_rst_n, r_st.pending_cr, !r_st.pending_escape)
    `CRT_ASSERT_NOW(a_escape_in_quotes, i_clk, i_rst_n, r_st.pending_escape, r_st.inside_quotes)
    `CRT_ASSERT_NEXT(a_eoi_restart, i_clk, i_rst_n, in_acc && i_in_chan.end_of_input, !r_st.inside_quotes && !r_st.pending_cr && !r_st.pending_escape && r_st.current_column == 6'd0 && !r_st.line_has_bytes)
    `CRT_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, n_push != 2'd0, o_out_chan.valid)

endmodule

### verif/csv_record_tokenizer_core_tb.sv
module csv_record_tokenizer_core_tb;
    import crt_pkg::*;

    localparam int COLUMN_CAP   = 64;
    localparam int NULL_CAP     = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 80;     // sink hold-off that backs up the block
    localparam int SETTLE       = 8;      // idle cycles before register writes
    localparam int PHASE_ITEMS  = 48;
    localparam int PHASES       = 6;

    typedef struct {
        logic [7:0]  delim;
        logic [7:0]  quote;
        logic [7:0]  escape;
        logic [63:0] null_text;
        logic [3:0]  null_bytes;
        logic [6:0]  col_limit;
        logic [6:0]  min_cols;
        logic [63:0] not_null;
    } tok_settings_t;

    // One hand-written request; the want_* fields are only used when has_want is set.
    typedef struct {
        logic [7:0]  req_byte;
        logic        req_eoi;
        bit          has_want;
        t_event_kind want_kind;
        logic [7:0]  want_data;
        logic [5:0]  want_col;
        logic        want_null;
        logic [6:0]  want_count;
        t_rec_status want_status;
    } directed_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    crt_in_if  in_ch ();
    crt_out_if out_ch ();

    csv_record_tokenizer_core #(
        .MAX_COLUMNS    (COLUMN_CAP),
        .NULL_MAX_BYTES (NULL_CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_chan   (in_ch),
        .o_out_chan  (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench copy of the register file and tokenizer state
    // ------------------------------------------------------------------
    logic [7:0]  cfg_delim, cfg_quote, cfg_escape;
    logic [63:0] cfg_null_text, cfg_not_null;
    logic [3:0]  cfg_null_bytes;
    logic [6:0]  cfg_col_limit, cfg_min_cols;

    bit          quote_open, esc_pending, cr_pending;
    bit          null_match, quoted_field, line_started;
    logic [5:0]  cur_col;
    logic [6:0]  field_total;
    logic [3:0]  raw_len;

    t_result     step_events[$];     // events of the request being worked out
    t_result     pending_events[$];  // events still owed by the block

    // Run control shared between processes
    int unsigned cycle_count = 0;
    int          err_count = 0;
    int          src_gap_pct = 20;
    int          sink_stall_pct = 20;
    bit          quiet_tail = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          wide_due = 1'b0;
    int          phase_items;
    logic [8:0]  line_bytes[$];      // {end_of_input, byte} per request

    // Hand-written opener at reset settings (comma, double quote, empty null string).
    directed_row_t directed_rows [24] = '{
        '{8'h61, 1'b0, 1'b1, EV_DATA, 8'h61, 6'd0, 1'b0, 7'd0, RS_OK},
        '{DEF_DELIMITER, 1'b0, 1'b1, EV_FIELD_END, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        // empty field matches the empty null string
        '{DEF_DELIMITER, 1'b0, 1'b1, EV_FIELD_END, 8'h00, 6'd1, 1'b1, 7'd0, RS_OK},
        '{DEF_QUOTE, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{8'h78, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{DEF_QUOTE, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{DEF_QUOTE, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{DEF_QUOTE, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        // LF after a pending quote closes the quote, then ends the record
        '{CH_LF, 1'b0, 1'b1, EV_RECORD_END, 8'h00, 6'd2, 1'b0, 7'd3, RS_OK},
        '{CH_CR, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{CH_LF, 1'b0, 1'b1, EV_RECORD_END, 8'h00, 6'd0, 1'b1, 7'd1, RS_OK},
        '{CH_CR, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{8'h62, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{8'hFF, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{8'h00, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        // quote opening mid-field, then end of input inside it
        '{DEF_QUOTE, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{8'hA5, 1'b1, 1'b1, EV_RECORD_END, 8'h00, 6'd0, 1'b0, 7'd1, RS_UNTERMINATED},
        '{8'h5A, 1'b1, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{DEF_QUOTE, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{DEF_QUOTE, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{8'hC3, 1'b1, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{8'h7A, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{CH_CR, 1'b0, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK},
        '{8'h3C, 1'b1, 1'b0, EV_DATA, 8'h00, 6'd0, 1'b0, 7'd0, RS_OK}
    };

    // ------------------------------------------------------------------
    // Tokenizer behavior
    // ------------------------------------------------------------------
    function automatic logic [5:0] top_column();
        int lim;
        lim = (cfg_col_limit < COLUMN_CAP) ? int'(cfg_col_limit) : COLUMN_CAP;
        return (lim == 0) ? 6'd0 : 6'(lim - 1);
    endfunction

    function automatic bit null_verdict();
        if (cfg_col_limit == 0 || quoted_field || !null_match) return 1'b0;
        if (cfg_null_bytes > NULL_CAP || raw_len != cfg_null_bytes) return 1'b0;
        if (cfg_not_null[cur_col]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic add_event(t_event_kind kind, logic [7:0] b, bit is_null,
                             logic [6:0] count, t_rec_status status);
        t_result r;
        r.kind          = kind;
        r.data_byte     = b;
        r.column_index  = cur_col;
        r.field_is_null = is_null;
        r.column_count  = count;
        r.status        = status;
        r.last_of_run   = 1'b0;
        step_events.push_back(r);
    endtask

    task automatic new_field();
        raw_len      = 4'd0;
        null_match   = 1'b1;
        quoted_field = 1'b0;
    endtask

    task automatic new_record();
        quote_open   = 1'b0;
        esc_pending  = 1'b0;
        cr_pending   = 1'b0;
        cur_col      = 6'd0;
        field_total  = 7'd1;
        line_started = 1'b0;
        new_field();
    endtask

    // status priority: unterminated, too many, too few
    task automatic close_record(bit unterminated);
        logic [6:0]  count;
        t_rec_status status;
        count = (cfg_col_limit == 0 && !line_started) ? 7'd0 : field_total;
        if (unterminated)               status = RS_UNTERMINATED;
        else if (count > cfg_col_limit) status = RS_TOO_MANY;
        else if (count < cfg_min_cols)  status = RS_TOO_FEW;
        else                            status = RS_OK;
        add_event(EV_RECORD_END, 8'h00, null_verdict(), count, status);
        new_record();
    endtask

    task automatic note_raw(logic [7:0] b);
        if (raw_len >= NULL_CAP)
            null_match = 1'b0;
        else if (cfg_null_text[8*raw_len +: 8] != b)
            null_match = 1'b0;
        if (raw_len < 4'd15)
            raw_len++;
    endtask

    // outside quotes: quote, then CR, then LF, then delimiter
    task automatic outside_byte(logic [7:0] b);
        if (b == cfg_quote) begin
            quote_open   = 1'b1;
            quoted_field = 1'b1;
            line_started = 1'b1;
        end else if (b == CH_CR) begin
            cr_pending = 1'b1;
        end else if (b == CH_LF) begin
            close_record(1'b0);
        end else if (b == cfg_delim) begin
            line_started = 1'b1;
            add_event(EV_FIELD_END, 8'h00, null_verdict(), 7'd0, RS_OK);
            if (cur_col < top_column()) cur_col++;
            if (field_total < COLUMN_CAP + 1) field_total++;
            new_field();
        end else begin
            line_started = 1'b1;
            add_event(EV_DATA, b, 1'b0, 7'd0, RS_OK);
            note_raw(b);
        end
    endtask

    // inside quotes: escape first, then quote
    task automatic inside_byte(logic [7:0] b);
        line_started = 1'b1;
        if (b == cfg_escape)
            esc_pending = 1'b1;
        else if (b == cfg_quote)
            quote_open = 1'b0;
        else
            add_event(EV_DATA, b, 1'b0, 7'd0, RS_OK);
    endtask

    // Fills step_events with what one accepted request must produce.
    task automatic tokenize_request(logic [7:0] b, logic eoi);
        int last;
        step_events.delete();
        if (eoi) begin
            if (esc_pending) begin
                esc_pending = 1'b0;
                if (cfg_escape == cfg_quote)
                    quote_open = 1'b0;
                else
                    add_event(EV_DATA, cfg_escape, 1'b0, 7'd0, RS_OK);
            end
            if (cr_pending)        close_record(1'b0);
            else if (quote_open)   close_record(1'b1);
            else if (line_started) close_record(1'b0);
            else                   new_record();
        end else if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == cfg_quote || b == cfg_escape) begin
                add_event(EV_DATA, b, 1'b0, 7'd0, RS_OK);
            end else if (cfg_escape == cfg_quote) begin
                // the escape was really the closing quote
                quote_open = 1'b0;
                outside_byte(b);
            end else begin
                add_event(EV_DATA, cfg_escape, 1'b0, 7'd0, RS_OK);
                inside_byte(b);
            end
        end else if (cr_pending) begin
            cr_pending = 1'b0;
            close_record(1'b0);
            if (b != CH_LF) outside_byte(b);
        end else if (quote_open) begin
            inside_byte(b);
        end else begin
            outside_byte(b);
        end
        if (step_events.size() > 0) begin
            last = step_events.size() - 1;
            step_events[last].last_of_run = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Register writes
    // ------------------------------------------------------------------
    task automatic write_reg(t_cfg_index idx, logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic load_settings(tok_settings_t s);
        write_reg(CFG_DELIMITER,   64'(s.delim));
        write_reg(CFG_QUOTE,       64'(s.quote));
        write_reg(CFG_ESCAPE,      64'(s.escape));
        write_reg(CFG_NULL_TEXT,   s.null_text);
        write_reg(CFG_NULL_LENGTH, 64'(s.null_bytes));
        write_reg(CFG_COL_LIMIT,   64'(s.col_limit));
        write_reg(CFG_MIN_COLUMNS, 64'(s.min_cols));
        write_reg(CFG_NOT_NULL,    s.not_null);
        i_cfg_we       <= 1'b0;
        cfg_delim      = s.delim;
        cfg_quote      = s.quote;
        cfg_escape     = s.escape;
        cfg_null_text  = s.null_text;
        cfg_null_bytes = s.null_bytes;
        cfg_col_limit  = s.col_limit;
        cfg_min_cols   = s.min_cols;
        cfg_not_null   = s.not_null;
    endtask

    // Settings per phase; overlapping byte classes, zero and oversized limits,
    // and an oversized null length are all in here.
    function automatic tok_settings_t phase_settings(int p);
        tok_settings_t s;
        case (p)
            0: s = '{DEF_DELIMITER, DEF_QUOTE, DEF_QUOTE, 64'h4E5C, 4'd2,
                     DEF_COL_LIMIT, 7'd0, 64'h0};
            // escape differs from quote, small limit saturates columns
            1: s = '{8'h3B, 8'h27, 8'h5C, 64'h414E, 4'd2, 7'd4, 7'd2, 64'h2};
            // escape equals delimiter, zero column limit, full-width null text
            2: s = '{8'h00, 8'hFF, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 7'd0,
                     7'd64, 64'hFFFF_FFFF_FFFF_FFFF};
            // delimiter is LF and quote is CR; null length beyond its storage
            3: s = '{CH_LF, CH_CR, 8'h78, {$urandom, $urandom}, 4'd12, 7'd100,
                     7'd70, {$urandom, $urandom}};
            4: s = '{8'h09, DEF_QUOTE, 8'h5C, 64'h0, 4'd0, DEF_COL_LIMIT, 7'd0,
                     64'h8000_0000_0000_0001};
            default: s = '{DEF_DELIMITER, DEF_QUOTE, DEF_QUOTE, 64'h4C4C_554E, 4'd4,
                           7'd3, 7'd1, 64'h0};
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_request(logic [7:0] b, logic eoi);
        if (!quiet_tail && $urandom_range(0, 99) < src_gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.end_of_input <= eoi;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        tokenize_request(b, eoi);
    endtask

    task automatic queue_predicted();
        foreach (step_events[i]) pending_events.push_back(step_events[i]);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Record generator
    // ------------------------------------------------------------------
    task automatic put_byte(logic [7:0] b);
        line_bytes.push_back({1'b0, b});
    endtask

    task automatic put_end();
        line_bytes.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    // byte with no special meaning under the current settings, when one is found
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'h00;
        for (int t = 0; t < 8; t++) begin
            if ($urandom_range(0, 7) == 0)
                b = 8'($urandom_range(0, 255));
            else
                b = 8'($urandom_range(8'h20, 8'h7E));
            if (b != cfg_delim && b != cfg_quote && b != cfg_escape &&
                b != CH_CR && b != CH_LF)
                return b;
        end
        return b;
    endfunction

    task automatic put_quoted();
        int n;
        put_byte(cfg_quote);
        n = $urandom_range(0, 5);
        repeat (n) begin
            case ($urandom_range(0, 6))
                0, 1: put_byte(plain_byte());
                2: put_byte(cfg_delim);
                3: put_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
                4: begin put_byte(cfg_escape); put_byte(cfg_quote); end
                5: begin put_byte(cfg_escape); put_byte(cfg_escape); end
                default: begin put_byte(cfg_escape); put_byte(plain_byte()); end
            endcase
        end
        put_byte(cfg_quote);
    endtask

    task automatic build_line();
        int  nfields, cap, n;
        bit  wide;
        line_bytes.delete();
        // noise: raw bytes with the odd end-of-input
        if (!wide_due && $urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0) put_end();
                else put_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        wide = (cfg_col_limit >= COLUMN_CAP) && (wide_due || $urandom_range(0, 11) == 0);
        wide_due = 1'b0;
        cap = (cfg_col_limit < 6) ? int'(cfg_col_limit) + 2 : 6;
        nfields = wide ? $urandom_range(62, 70) : $urandom_range(1, cap);
        for (int f = 0; f < nfields; f++) begin
            if (f > 0) put_byte(cfg_delim);
            case (wide ? 2 * $urandom_range(0, 1) : $urandom_range(0, 5))
                0: ;  // empty
                1: for (int i = 0; i < cfg_null_bytes && i < NULL_CAP; i++)
                       put_byte(cfg_null_text[8*i +: 8]);
                2, 3: begin
                    n = wide ? 1 : $urandom_range(1, 5);
                    repeat (n) put_byte(plain_byte());
                end
                4: put_quoted();
                default: begin
                    put_byte(plain_byte());
                    put_quoted();
                end
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: put_byte(CH_LF);
            4, 5: put_byte(CH_CR);
            6, 7: begin put_byte(CH_CR); put_byte(CH_LF); end
            8: put_end();
            default: begin
                // quote left open, sometimes on a dangling escape
                put_byte(cfg_quote);
                put_byte(plain_byte());
                if ($urandom_range(0, 1)) put_byte(cfg_escape);
                put_end();
            end
        endcase
    endtask

    task automatic send_line();
        build_line();
        foreach (line_bytes[i]) begin
            send_request(line_bytes[i][7:0], line_bytes[i][8]);
            queue_predicted();
        end
        phase_items += line_bytes.size();
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        $display("mismatch at cycle %0d: %s got %0h want %0h",
                 cycle_count, what, got, want);
    endtask

    // Sampled at the falling edge, so values are the ones the next rising
    // edge transfers, and no request predicted at that rising edge can race.
    always @(negedge i_clk) begin : event_check
        t_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_events.size() == 0) begin
                note_mismatch("event with none pending", {62'd0, out_ch.event_kind}, 64'd0);
            end else begin
                want = pending_events.pop_front();
                if (out_ch.event_kind !== want.kind)
                    note_mismatch("event_kind", 64'(out_ch.event_kind), 64'(want.kind));
                if (out_ch.data_byte !== want.data_byte)
                    note_mismatch("data_byte", 64'(out_ch.data_byte),
                                  64'(want.data_byte));
                if (out_ch.column_index !== want.column_index)
                    note_mismatch("column_index", 64'(out_ch.column_index),
                                  64'(want.column_index));
                if (out_ch.field_is_null !== want.field_is_null)
                    note_mismatch("field_is_null", 64'(out_ch.field_is_null),
                                  64'(want.field_is_null));
                if (out_ch.column_count !== want.column_count)
                    note_mismatch("column_count", 64'(out_ch.column_count),
                                  64'(want.column_count));
                if (out_ch.record_status !== want.status)
                    note_mismatch("record_status", 64'(out_ch.record_status),
                                  64'(want.status));
                if (out_ch.last_of_run !== want.last_of_run)
                    note_mismatch("last_of_run", 64'(out_ch.last_of_run),
                                  64'(want.last_of_run));
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request
    // from the stimulus so the result queue fills and input ready drops.
    initial begin : event_sink
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 99) < sink_stall_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[csv_record_tokenizer_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_result       want;
        directed_row_t row;
        int            src_pct_by_phase  [PHASES] = '{30, 0, 50, 20, 25, 0};
        int            sink_pct_by_phase [PHASES] = '{30, 0, 50, 40, 25, 0};

        in_ch.valid        <= 1'b0;
        in_ch.in_byte      <= 8'h00;
        in_ch.end_of_input <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_DELIMITER;
        i_cfg_data         <= 64'd0;
        i_rst_n            <= 1'b0;

        // bench state matches the block's reset
        cfg_delim      = DEF_DELIMITER;
        cfg_quote      = DEF_QUOTE;
        cfg_escape     = DEF_QUOTE;
        cfg_null_text  = 64'd0;
        cfg_null_bytes = 4'd0;
        cfg_col_limit  = DEF_COL_LIMIT;
        cfg_min_cols   = 7'd0;
        cfg_not_null   = 64'd0;
        new_record();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hand-written opener; typed expectations stand in for the
        // prediction where the outcome is obvious.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.req_byte, row.req_eoi);
            if (row.has_want) begin
                want.kind          = row.want_kind;
                want.data_byte     = row.want_data;
                want.column_index  = row.want_col;
                want.field_is_null = row.want_null;
                want.column_count  = row.want_count;
                want.status        = row.want_status;
                want.last_of_run   = 1'b1;
                pending_events.push_back(want);
            end else begin
                queue_predicted();
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            // registers only change with the block empty and quiet
            wait_drained();
            repeat (SETTLE) @(posedge i_clk);
            load_settings(phase_settings(p));
            src_gap_pct    = src_pct_by_phase[p];
            sink_stall_pct = sink_pct_by_phase[p];
            quiet_tail     = (p == PHASES - 1);
            wide_due       = (p == 4);
            if (p == 0) long_hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) send_line();
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (pending_events.size() != 0)
            note_mismatch("events never delivered", 64'(pending_events.size()), 64'd0);
        if (err_count == 0)
            $display("[csv_record_tokenizer_core] OK");
        else
            $display("[csv_record_tokenizer_core] ERROR");
        $finish;
    end
endmodule
